// ===== rtl/lja_pkg.sv =====
// ----------------------------------------------------------------------------
// lja_pkg: shared constants for the LCG jump-ahead block
// Generator constants, and per-bit jump coefficients built at elaboration.
// ----------------------------------------------------------------------------
`default_nettype none

package lja_pkg;

    localparam int unsigned STATE_W = 32;
    localparam int unsigned COUNT_W = 32;
    localparam int unsigned NUM_STAGES = COUNT_W;

    localparam logic [STATE_W-1:0] LCG_MUL = 32'h0003_43FD;
    localparam logic [STATE_W-1:0] LCG_ADD = 32'h0026_9EC3;

    // multiplier of the map that advances 2^idx steps: a^(2^idx)
    function automatic logic [STATE_W-1:0] jump_mul(input int unsigned idx);
        logic [STATE_W-1:0] a;
        a = LCG_MUL;
        for (int unsigned k = 0; k < idx; k++)
        begin
            a = a * a;
        end
        return a;
    endfunction

    // addend of the map that advances 2^idx steps: (1 + a + ... + a^(2^idx - 1)) * c
    function automatic logic [STATE_W-1:0] jump_add(input int unsigned idx);
        logic [STATE_W-1:0] a;
        logic [STATE_W-1:0] s;
        a = LCG_MUL;
        s = 32'd1;
        for (int unsigned k = 0; k < idx; k++)
        begin
            s = s * (a + 32'd1);
            a = a * a;
        end
        return s * LCG_ADD;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/lcg_jump_ahead.sv =====
// ----------------------------------------------------------------------------
// lcg_jump_ahead: skip a 32-bit LCG state ahead by a given step count
// Applies one precomputed 2^k-step map per set bit of the count, one bit per
// pipeline stage.
//
//   channel | signals                               | direction
//   --------+---------------------------------------+----------
//   in      | in_valid, in_ready, start_state,      | request in
//           | step_count                            |
//   out     | out_valid, out_ready, end_state       | request out
//
// One request enters per cycle while in_ready is high; one stage per count bit,
// each stage one 32x32 multiply-add against constants.
// A zero count passes the state through unchanged (full period).
// rst_n clears all stage valid bits; the data registers are not reset.
// A stage holds while the stage after it is full and held; empty stages fill.
// ----------------------------------------------------------------------------
`default_nettype none

module lcg_jump_ahead
(
    input  wire logic        clk,
    input  wire logic        rst_n,

    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [31:0] start_state,
    input  wire logic [31:0] step_count,

    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [31:0]      end_state
);

    localparam int unsigned NS = lja_pkg::NUM_STAGES;
    localparam int unsigned SW = lja_pkg::STATE_W;
    localparam int unsigned CW = lja_pkg::COUNT_W;

    logic [NS-1:0] vld_reg;
    logic [NS-1:0] stage_en;
    logic [SW-1:0] y_reg [NS];
    logic [CW-1:0] n_reg [NS];

    always_comb
    begin
        stage_en[NS-1] = !vld_reg[NS-1] || out_ready;
        for (int k = NS - 2; k >= 0; k--)
        begin
            stage_en[k] = !vld_reg[k] || stage_en[k+1];
        end
    end

    genvar i;
    generate
        for (i = 0; i < NS; i++)
        begin : g_stage
            localparam logic [SW-1:0] STAGE_MUL = lja_pkg::jump_mul(i);
            localparam logic [SW-1:0] STAGE_ADD = lja_pkg::jump_add(i);

            logic          vld_in;
            logic [SW-1:0] y_in;
            logic [CW-1:0] n_in;
            logic [SW-1:0] y_next;

            if (i == 0)
            begin : g_first
                assign vld_in = in_valid;
                assign y_in   = start_state;
                assign n_in   = step_count;
            end
            else
            begin : g_rest
                assign vld_in = vld_reg[i-1];
                assign y_in   = y_reg[i-1];
                assign n_in   = n_reg[i-1];
            end

            assign y_next = n_in[i] ? (y_in * STAGE_MUL + STAGE_ADD) : y_in;

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    vld_reg[i] <= 1'b0;
                end
                else if (stage_en[i])
                begin
                    vld_reg[i] <= vld_in;
                end
            end

            always_ff @(posedge clk)
            begin
                if (stage_en[i] && vld_in)
                begin
                    y_reg[i] <= y_next;
                    n_reg[i] <= n_in;
                end
            end
        end
    endgenerate

    assign in_ready  = stage_en[0];
    assign out_valid = vld_reg[NS-1];
    assign end_state = y_reg[NS-1];

endmodule

`default_nettype wire

// ===== rtl/lja_checker.sv =====
// ----------------------------------------------------------------------------
// lja_sva: port-level checks for lcg_jump_ahead
// Watches the handshakes and the flow-through behavior of the pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

module lja_sva
(
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        in_valid,
    input wire logic        in_ready,
    input wire logic [31:0] start_state,
    input wire logic [31:0] step_count,
    input wire logic        out_valid,
    input wire logic        out_ready,
    input wire logic [31:0] end_state
);

    a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_ready |=> in_valid && $stable(start_state) && $stable(step_count))
        else $error("request changed while stalled");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result dropped while stalled");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(end_state))
        else $error("result changed while stalled");

    a_flow: assert property (@(posedge clk) disable iff (!rst_n)
        out_ready |-> in_ready)
        else $error("input blocked while output drains");

    a_reset_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !$past(rst_n) |-> !out_valid)
        else $error("result shown right after reset");

endmodule

bind lcg_jump_ahead lja_sva u_lja_sva
(
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .start_state (start_state),
    .step_count  (step_count),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .end_state   (end_state)
);

`default_nettype wire

// ===== bench/lja_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lja_checker: scoreboard for the LCG jump-ahead block
// Watches both request channels. Each accepted request is advanced by its
// step count with a bit-serial doubling model of the generator. Each accepted
// result is compared in order with the oldest prediction.
// ----------------------------------------------------------------------------

module lja_checker
(
    input  logic        clk,
    input  logic        rst_n,

    input  logic        in_valid,
    input  logic        in_ready,
    input  logic [31:0] start_state,
    input  logic [31:0] step_count,

    input  logic        out_valid,
    input  logic        out_ready,
    input  logic [31:0] end_state,

    output int          fail_count,
    output int          pending
);

    logic [lja_pkg::STATE_W-1:0] jumped_q[$];
    int                          mismatches = 0;

    function automatic logic [lja_pkg::STATE_W-1:0] jump_state(
        input logic [lja_pkg::STATE_W-1:0] seed,
        input logic [lja_pkg::COUNT_W-1:0] steps);
        logic [lja_pkg::STATE_W-1:0] mul_pow;
        logic [lja_pkg::STATE_W-1:0] geo_sum;
        mul_pow = 32'd1;
        geo_sum = 32'd0;
        for (int b = lja_pkg::COUNT_W - 1; b >= 0; b--)
        begin
            geo_sum = geo_sum * (32'd1 + mul_pow);
            mul_pow = mul_pow * mul_pow;
            if (steps[b])
            begin
                geo_sum = geo_sum * lja_pkg::LCG_MUL + 32'd1;
                mul_pow = mul_pow * lja_pkg::LCG_MUL;
            end
        end
        return seed * mul_pow + geo_sum * lja_pkg::LCG_ADD;
    endfunction

    always @(posedge clk)
    begin
        logic [lja_pkg::STATE_W-1:0] want;
        if (rst_n)
        begin
            if (in_valid && in_ready)
                jumped_q = {jumped_q, jump_state(start_state, step_count)};
            if (out_valid && out_ready)
            begin
                if (jumped_q.size() == 0)
                begin
                    $error("end_state with no request pending: expected none, actual %h",
                           end_state);
                    mismatches++;
                end
                else
                begin
                    want = jumped_q.pop_front();
                    if (end_state !== want)
                    begin
                        $error("end_state mismatch: expected %h, actual %h", want, end_state);
                        mismatches++;
                    end
                end
            end
            fail_count <= mismatches;
            pending    <= jumped_q.size();
        end
    end

endmodule

// ===== bench/lcg_jump_ahead_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcg_jump_ahead_tb: regression bench for the LCG jump-ahead block
// Drives directed edge cases and random start states and step counts with
// random idle cycles on both channels; a separate checker predicts and
// compares every result. A watchdog ends a stalled run.
// ----------------------------------------------------------------------------

module lcg_jump_ahead_tb;

    localparam int IDLE_PCT     = 34;
    localparam int STALL_MAX    = 2000;
    localparam int DIRECTED_CNT = 20;
    localparam int RANDOM_CNT   = 1800;
    localparam int TOTAL_CNT    = DIRECTED_CNT + RANDOM_CNT;
    localparam int CALM_LO      = 700;
    localparam int CALM_HI      = 1000;

    logic        clk         = 1'b0;
    logic        rst_n       = 1'b0;
    logic        in_valid    = 1'b0;
    logic        in_ready;
    logic [31:0] start_state = 32'd0;
    logic [31:0] step_count  = 32'd0;
    logic        out_valid;
    logic        out_ready   = 1'b0;
    logic [31:0] end_state;

    logic        calm        = 1'b0;
    int          fail_count;
    int          pending;
    int          stall_cycles = 0;

    logic [31:0] starts_q [TOTAL_CNT];
    logic [31:0] counts_q [TOTAL_CNT];
    int          fill_idx = 0;

    lcg_jump_ahead dut
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .start_state (start_state),
        .step_count  (step_count),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .end_state   (end_state)
    );

    lja_checker u_checker
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .start_state (start_state),
        .step_count  (step_count),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .end_state   (end_state),
        .fail_count  (fail_count),
        .pending     (pending)
    );

    initial
    begin
        forever
        begin
            #5 clk = ~clk;
        end
    end

    always @(posedge clk)
    begin
        if (calm)
            out_ready <= 1'b1;
        else
            out_ready <= ($urandom_range(99) >= IDLE_PCT);
    end

    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || !rst_n)
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_MAX)
        begin
            $display("lcg_jump_ahead regression: fail");
            $finish;
        end
    end

    function automatic logic [31:0] pick_count();
        case ($urandom_range(9))
            0, 1, 2, 3: pick_count = $urandom;
            4:          pick_count = $urandom_range(40);
            5:          pick_count = 32'd1 << $urandom_range(31);
            6:          pick_count = ~(32'd1 << $urandom_range(31));
            7:          pick_count = 32'd0;
            8:          pick_count = 32'hFFFF_FFFF - $urandom_range(40);
            default:    pick_count = $urandom & $urandom;
        endcase
    endfunction

    function automatic logic [31:0] pick_start();
        case ($urandom_range(15))
            0:       pick_start = 32'd0;
            1:       pick_start = 32'hFFFF_FFFF;
            default: pick_start = $urandom;
        endcase
    endfunction

    task automatic add_request(input logic [31:0] s, input logic [31:0] c);
        starts_q[fill_idx] = s;
        counts_q[fill_idx] = c;
        fill_idx++;
    endtask

    initial
    begin
        int sent;
        int total;

        add_request(32'h0000_0000, 32'h0000_0000);
        add_request(32'hFFFF_FFFF, 32'h0000_0000);
        add_request(32'h1234_5678, 32'h0000_0000);
        add_request(32'h0000_0000, 32'h0000_0001);
        add_request(32'hFFFF_FFFF, 32'h0000_0001);
        add_request(32'h0000_0001, 32'h0000_0002);
        add_request(32'h0000_0000, 32'hFFFF_FFFF);
        add_request(32'hFFFF_FFFF, 32'hFFFF_FFFF);
        add_request(32'hDEAD_BEEF, 32'h8000_0000);
        add_request(32'h8000_0000, 32'h4000_0000);
        add_request(32'h0000_0001, 32'h0001_0000);
        add_request(32'h5555_5555, 32'hAAAA_AAAA);
        add_request(32'hAAAA_AAAA, 32'h5555_5555);
        add_request(32'h0000_0000, 32'h7FFF_FFFF);
        add_request(32'h7FFF_FFFF, 32'h8000_0001);
        add_request(32'h0F0F_0F0F, 32'hF0F0_F0F0);
        add_request(32'hF0F0_F0F0, 32'h0F0F_0F0F);
        add_request(32'h0000_0001, 32'h0000_0003);
        add_request(32'hCAFE_F00D, 32'hFFFF_FFFE);
        add_request(32'h0000_0000, 32'h0000_0100);
        for (int i = 0; i < RANDOM_CNT; i++)
            add_request(pick_start(), pick_count());

        total = fill_idx;
        sent  = 0;

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        while (sent < total)
        begin
            @(posedge clk);
            if (in_valid && in_ready)
                sent++;
            calm <= (sent >= CALM_LO) && (sent < CALM_HI);
            if (in_valid && !in_ready)
            begin
                // hold
            end
            else if (sent < total && (calm || $urandom_range(99) >= IDLE_PCT))
            begin
                in_valid    <= 1'b1;
                start_state <= starts_q[sent];
                step_count  <= counts_q[sent];
            end
            else
            begin
                in_valid <= 1'b0;
            end
        end

        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);

        if (fail_count == 0 && pending == 0)
            $display("lcg_jump_ahead regression: pass");
        else
            $display("lcg_jump_ahead regression: fail");
        $finish;
    end

endmodule
